// ===== hdl/fdcs_pkg.sv =====
`default_nettype none
package fdcs_pkg;

  localparam int unsigned TRACK_W = 8;
  localparam int unsigned ADDR_W  = 4;

  localparam logic [TRACK_W-1:0] TRACK_LIMIT_RST = TRACK_W'(80);

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_STATUS = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  // command registers
  localparam logic [ADDR_W-1:0] CMD_STEP_DIR    = 4'd0;
  localparam logic [ADDR_W-1:0] CMD_STEP        = 4'd1;
  localparam logic [ADDR_W-1:0] CMD_MOTOR       = 4'd2;
  localparam logic [ADDR_W-1:0] CMD_EJECT       = 4'd3;
  localparam logic [ADDR_W-1:0] CMD_CLEAR_EJECT = 4'd4;
  localparam logic [ADDR_W-1:0] CMD_DRIVE_MODE  = 4'd5;

  // status registers
  localparam logic [ADDR_W-1:0] ST_STEP_STATUS  = 4'd0;
  localparam logic [ADDR_W-1:0] ST_MOTOR        = 4'd1;
  localparam logic [ADDR_W-1:0] ST_EJECT_LATCH  = 4'd2;
  localparam logic [ADDR_W-1:0] ST_SEL_HEAD0    = 4'd3;
  localparam logic [ADDR_W-1:0] ST_MFM_SUPPORT  = 4'd4;
  localparam logic [ADDR_W-1:0] ST_DOUBLE_SIDED = 4'd5;
  localparam logic [ADDR_W-1:0] ST_DRIVE_EXISTS = 4'd6;
  localparam logic [ADDR_W-1:0] ST_DISK_IN      = 4'd7;
  localparam logic [ADDR_W-1:0] ST_WRITE_PROT   = 4'd8;
  localparam logic [ADDR_W-1:0] ST_TRACK_ZERO   = 4'd9;
  localparam logic [ADDR_W-1:0] ST_SEL_HEAD1    = 4'd10;
  localparam logic [ADDR_W-1:0] ST_DRIVE_MODE   = 4'd11;
  localparam logic [ADDR_W-1:0] ST_SPIN_READY   = 4'd12;
  localparam logic [ADDR_W-1:0] ST_MEDIA_KIND   = 4'd13;

  typedef struct packed {
    logic [1:0]         operation;
    logic [ADDR_W-1:0]  reg_addr;
    logic               cmd_value;
    logic [TRACK_W-1:0] disk_tracks;
    logic               disk_write_protect;
    logic               disk_high_density;
    logic               disk_gcr;
  } item_t;

  typedef struct packed {
    logic status_bit;
    logic insert_rejected;
  } result_t;

  typedef struct packed {
    logic               step_inward;
    logic [TRACK_W-1:0] head_track;
    logic               motor_on;
    logic               eject_latched;
    logic               disk_present;
    logic               write_protected;
    logic               hd_media;
    logic               mfm_mode;
    logic               spin_ready;
    logic               head_select;
    logic [TRACK_W-1:0] track_limit;
  } drive_state_t;

endpackage
`default_nettype wire

// ===== hdl/floppy_drive_command_status.sv =====
// An accepted item passes through the input register and then the result register before out_valid rises.
// Throughput: one item per cycle unless out_ready stalls; the drive state updates as an
// item enters the result register, so the next item sees it without a bubble.
// Stalls on out_ready hold the result register and back up into the input register.
// Reset: synchronous active-low rst_n clears both stages and loads drive reset state.
`default_nettype none
module floppy_drive_command_status (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [3:0] in_reg_addr,
  input  wire logic       in_cmd_value,
  input  wire logic [7:0] in_disk_tracks,
  input  wire logic       in_disk_write_protect,
  input  wire logic       in_disk_high_density,
  input  wire logic       in_disk_gcr,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_status_bit,
  output logic            out_insert_rejected
);
  import fdcs_pkg::*;

  item_t   in_item, s1_item;
  result_t s1_result, out_result;
  logic    s1_valid, take, advance;

  assign in_item.operation          = in_operation;
  assign in_item.reg_addr           = in_reg_addr;
  assign in_item.cmd_value          = in_cmd_value;
  assign in_item.disk_tracks        = in_disk_tracks;
  assign in_item.disk_write_protect = in_disk_write_protect;
  assign in_item.disk_high_density  = in_disk_high_density;
  assign in_item.disk_gcr           = in_disk_gcr;

  assign advance = s1_valid && take;

  fdcs_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item     (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fdcs_drive u_drive (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item),
    .result  (s1_result)
  );

  fdcs_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .take       (take),
    .result     (s1_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_status_bit      = out_result.status_bit;
  assign out_insert_rejected = out_result.insert_rejected;
endmodule
`default_nettype wire

// ===== hdl/fdcs_in_stage.sv =====
`default_nettype none
module fdcs_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fdcs_pkg::item_t item,
  input  wire logic           advance,
  output logic                s1_valid,
  output fdcs_pkg::item_t     s1_item
);
  import fdcs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule
`default_nettype wire

// ===== hdl/fdcs_drive.sv =====
`default_nettype none
module fdcs_drive (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            advance,
  input  wire fdcs_pkg::item_t item,
  output fdcs_pkg::result_t    result
);
  import fdcs_pkg::*;

  drive_state_t state_r, state_nxt;
  logic [TRACK_W:0]   step_sum;
  logic [TRACK_W-1:0] step_track;

  // clamp the stepped track into 0..track_limit-1
  always_comb begin
    if (state_r.step_inward) begin
      step_sum = (state_r.head_track == '0) ? '0
               : {1'b0, state_r.head_track} - (TRACK_W+1)'(1);
    end else begin
      step_sum = {1'b0, state_r.head_track} + (TRACK_W+1)'(1);
    end
    if (step_sum >= {1'b0, state_r.track_limit}) begin
      step_track = (state_r.track_limit == '0) ? '0
                 : state_r.track_limit - TRACK_W'(1);
    end else begin
      step_track = step_sum[TRACK_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    result    = '0;
    case (item.operation)
      OP_CMD: begin
        case (item.reg_addr)
          CMD_STEP_DIR: state_nxt.step_inward = item.cmd_value;
          CMD_STEP: begin
            if (!item.cmd_value) state_nxt.head_track = step_track;
          end
          CMD_MOTOR: begin
            if (state_r.motor_on == item.cmd_value) begin
              state_nxt.motor_on   = !item.cmd_value;
              state_nxt.spin_ready = !item.cmd_value;
            end
          end
          CMD_EJECT: begin
            if (item.cmd_value) begin
              state_nxt.eject_latched = 1'b1;
              state_nxt.hd_media      = 1'b1;
              state_nxt.disk_present  = 1'b0;
              state_nxt.motor_on      = 1'b0;
              state_nxt.head_track    = '0;
              state_nxt.spin_ready    = 1'b0;
              state_nxt.mfm_mode      = 1'b1;
            end
          end
          CMD_CLEAR_EJECT: begin
            if (item.cmd_value) state_nxt.eject_latched = 1'b0;
          end
          CMD_DRIVE_MODE: begin
            if (state_r.mfm_mode == item.cmd_value) begin
              state_nxt.mfm_mode   = !item.cmd_value;
              state_nxt.spin_ready = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_STATUS: begin
        case (item.reg_addr)
          ST_STEP_STATUS:  result.status_bit = 1'b1;
          ST_MOTOR:        result.status_bit = !state_r.motor_on;
          ST_EJECT_LATCH:  result.status_bit = state_r.eject_latched;
          ST_SEL_HEAD0:    state_nxt.head_select = 1'b0;
          ST_MFM_SUPPORT:  result.status_bit = 1'b1;
          ST_DOUBLE_SIDED: result.status_bit = 1'b1;
          ST_DRIVE_EXISTS: result.status_bit = 1'b0;
          ST_DISK_IN:      result.status_bit = !state_r.disk_present;
          ST_WRITE_PROT:   result.status_bit = !state_r.write_protected;
          ST_TRACK_ZERO:   result.status_bit = (state_r.head_track != '0);
          ST_SEL_HEAD1: begin
            state_nxt.head_select = 1'b1;
            result.status_bit     = 1'b1;
          end
          ST_DRIVE_MODE:   result.status_bit = state_r.mfm_mode;
          ST_SPIN_READY:   result.status_bit = !state_r.spin_ready;
          ST_MEDIA_KIND:   result.status_bit = !state_r.hd_media;
          default: ;
        endcase
      end
      OP_INSERT: begin
        if (state_r.disk_present) begin
          result.insert_rejected = 1'b1;
        end else begin
          state_nxt.track_limit     = item.disk_tracks;
          state_nxt.hd_media        = item.disk_high_density;
          state_nxt.mfm_mode        = !item.disk_gcr;
          state_nxt.write_protected = item.disk_write_protect;
          state_nxt.disk_present    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // commit state only when the item moves on to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.step_inward     <= 1'b0;
      state_r.head_track      <= '0;
      state_r.motor_on        <= 1'b0;
      state_r.eject_latched   <= 1'b0;
      state_r.disk_present    <= 1'b0;
      state_r.write_protected <= 1'b0;
      state_r.hd_media        <= 1'b1;
      state_r.mfm_mode        <= 1'b1;
      state_r.spin_ready      <= 1'b0;
      state_r.head_select     <= 1'b0;
      state_r.track_limit     <= TRACK_LIMIT_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/fdcs_out_stage.sv =====
`default_nettype none
module fdcs_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  output logic                   take,
  input  wire fdcs_pkg::result_t result,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fdcs_pkg::result_t      out_result
);
  import fdcs_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign take      = !valid_r || out_ready;
  assign valid_nxt = advance || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
endmodule
`default_nettype wire

// ===== hdl/fdcs_checker.sv =====
`default_nettype none
module fdcs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_status_bit,
  input wire logic       out_insert_rejected
);

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status_bit)
                                && $stable(out_insert_rejected))
    else $error("stalled result changed or dropped");

  // a rejected insert carries no sense bit
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_insert_rejected |-> !out_status_bit)
    else $error("rejected insert with status bit set");

  // an item taken during a stall fills the input register, so ready drops
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && $past(out_valid && !out_ready)
      && $past(in_valid && in_ready) && $past(rst_n) |-> !in_ready)
    else $error("input accepted with both stages full");

  // an empty result register always lets the input move
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while result register empty");

endmodule

bind floppy_drive_command_status fdcs_checker u_fdcs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status_bit      (out_status_bit),
  .out_insert_rejected (out_insert_rejected)
);
`default_nettype wire

// ===== dv/floppy_drive_command_status_tb.sv =====
`timescale 1ns / 100ps
module floppy_drive_command_status_tb;
  import fdcs_pkg::*;

  localparam logic [1:0]        OP_UNKNOWN   = 2'd3;
  localparam logic [ADDR_W-1:0] REG_UNKNOWN  = 4'd15;
  localparam int                CYCLE_LIMIT  = 200000;
  localparam int                TAIL_CYCLES  = 20;
  localparam int                PHASE_ITEMS  = 283;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = '0;
  logic [ADDR_W-1:0]  in_reg_addr = '0;
  logic               in_cmd_value = 1'b0;
  logic [TRACK_W-1:0] in_disk_tracks = '0;
  logic               in_disk_write_protect = 1'b0;
  logic               in_disk_high_density = 1'b0;
  logic               in_disk_gcr = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_status_bit;
  logic               out_insert_rejected;

  floppy_drive_command_status u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_operation          (in_operation),
    .in_reg_addr           (in_reg_addr),
    .in_cmd_value          (in_cmd_value),
    .in_disk_tracks        (in_disk_tracks),
    .in_disk_write_protect (in_disk_write_protect),
    .in_disk_high_density  (in_disk_high_density),
    .in_disk_gcr           (in_disk_gcr),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status_bit        (out_status_bit),
    .out_insert_rejected   (out_insert_rejected)
  );

  always #4 clk = ~clk;

  item_t        pending_accesses[$];
  result_t      expected_sense[$];
  drive_state_t drive;

  int send_idle_pct = 31;
  int recv_idle_pct = 62;
  int queued_cnt    = 0;
  int accepted_cnt  = 0;
  int err_count     = 0;
  int cycle_cnt     = 0;
  int cmd_cnt       = 0;
  int status_cnt    = 0;
  int insert_cnt    = 0;
  int reject_cnt    = 0;
  logic in_accepted = 1'b0;

  // Drive behavior: apply one access to the shadow drive and return its sense result.
  function automatic result_t predict_access(item_t a);
    result_t r;
    int      t;
    r = '0;
    case (a.operation)
      OP_CMD: begin
        case (a.reg_addr)
          CMD_STEP_DIR: drive.step_inward = a.cmd_value;
          CMD_STEP: begin
            if (!a.cmd_value) begin
              t = int'(drive.head_track) + (drive.step_inward ? -1 : 1);
              if (t < 0) begin
                t = 0;
              end else if (t >= int'(drive.track_limit)) begin
                t = (drive.track_limit == 0) ? 0 : int'(drive.track_limit) - 1;
              end
              drive.head_track = t[TRACK_W-1:0];
            end
          end
          CMD_MOTOR: begin
            if (drive.motor_on != ~a.cmd_value) begin
              drive.motor_on   = ~a.cmd_value;
              drive.spin_ready = ~a.cmd_value;
            end
          end
          CMD_EJECT: begin
            if (a.cmd_value) begin
              drive.eject_latched = 1'b1;
              drive.hd_media      = 1'b1;
              drive.disk_present  = 1'b0;
              drive.motor_on      = 1'b0;
              drive.head_track    = '0;
              drive.spin_ready    = 1'b0;
              drive.mfm_mode      = 1'b1;
            end
          end
          CMD_CLEAR_EJECT: begin
            if (a.cmd_value) drive.eject_latched = 1'b0;
          end
          CMD_DRIVE_MODE: begin
            if (drive.mfm_mode != ~a.cmd_value) begin
              drive.mfm_mode   = ~a.cmd_value;
              drive.spin_ready = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_STATUS: begin
        case (a.reg_addr)
          ST_STEP_STATUS:  r.status_bit = 1'b1;
          ST_MOTOR:        r.status_bit = ~drive.motor_on;
          ST_EJECT_LATCH:  r.status_bit = drive.eject_latched;
          ST_SEL_HEAD0: begin
            drive.head_select = 1'b0;
            r.status_bit      = 1'b0;
          end
          ST_MFM_SUPPORT:  r.status_bit = 1'b1;
          ST_DOUBLE_SIDED: r.status_bit = 1'b1;
          ST_DRIVE_EXISTS: r.status_bit = 1'b0;
          ST_DISK_IN:      r.status_bit = ~drive.disk_present;
          ST_WRITE_PROT:   r.status_bit = ~drive.write_protected;
          ST_TRACK_ZERO:   r.status_bit = (drive.head_track != 0);
          ST_SEL_HEAD1: begin
            drive.head_select = 1'b1;
            r.status_bit      = 1'b1;
          end
          ST_DRIVE_MODE:   r.status_bit = drive.mfm_mode;
          ST_SPIN_READY:   r.status_bit = ~drive.spin_ready;
          ST_MEDIA_KIND:   r.status_bit = ~drive.hd_media;
          default:         r.status_bit = 1'b0;
        endcase
      end
      OP_INSERT: begin
        if (drive.disk_present) begin
          r.insert_rejected = 1'b1;
        end else begin
          drive.track_limit     = a.disk_tracks;
          drive.hd_media        = a.disk_high_density;
          drive.mfm_mode        = ~a.disk_gcr;
          drive.write_protected = a.disk_write_protect;
          drive.disk_present    = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic item_t make_access(logic [1:0] op, logic [ADDR_W-1:0] addr, logic v,
                                        logic [TRACK_W-1:0] tracks, logic wp, logic hd,
                                        logic gcr);
    item_t a;
    a.operation          = op;
    a.reg_addr           = addr;
    a.cmd_value          = v;
    a.disk_tracks        = tracks;
    a.disk_write_protect = wp;
    a.disk_high_density  = hd;
    a.disk_gcr           = gcr;
    return a;
  endfunction

  // Mostly short disks so stepping hits both clamps; ejects are frequent
  // enough that inserts get through as well as bounce.
  function automatic item_t rand_access();
    item_t a;
    int    pick;
    a = make_access(OP_CMD, ADDR_W'($urandom_range(15)), 1'($urandom_range(1)),
                    TRACK_W'($urandom_range(255, 1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 40) begin
      a.operation = OP_CMD;
      if ($urandom_range(9) != 0) a.reg_addr = ADDR_W'($urandom_range(5));
      if ($urandom_range(4) == 0) begin
        a.reg_addr  = CMD_EJECT;
        a.cmd_value = 1'b1;
      end else if (a.reg_addr == CMD_STEP && $urandom_range(3) != 0) begin
        a.cmd_value = 1'b0;
      end
    end else if (pick < 82) begin
      a.operation = OP_STATUS;
    end else if (pick < 96) begin
      a.operation = OP_INSERT;
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: a.disk_tracks = TRACK_W'($urandom_range(4, 1));
        6:                a.disk_tracks = '1;
        default:          ;
      endcase
    end else begin
      a.operation = OP_UNKNOWN;
    end
    return a;
  endfunction

  task automatic queue_access(item_t a);
    pending_accesses.push_back(a);
    queued_cnt++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != queued_cnt || expected_sense.size() != 0);
  endtask

  // Sender and receiver; change inputs away from the sampling edge.
  always @(negedge clk) begin
    item_t nxt;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_valid || in_accepted) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_accesses.pop_front();
          in_operation          <= nxt.operation;
          in_reg_addr           <= nxt.reg_addr;
          in_cmd_value          <= nxt.cmd_value;
          in_disk_tracks        <= nxt.disk_tracks;
          in_disk_write_protect <= nxt.disk_write_protect;
          in_disk_high_density  <= nxt.disk_high_density;
          in_disk_gcr           <= nxt.disk_gcr;
          in_valid              <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    item_t   seen;
    result_t got;
    result_t want;
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      // check the outgoing result before queueing this edge's prediction
      if (out_valid && out_ready) begin
        got.status_bit      = out_status_bit;
        got.insert_rejected = out_insert_rejected;
        if (expected_sense.size() == 0) begin
          $display("%0t: unexpected result status_bit=%0b insert_rejected=%0b",
                   $time, got.status_bit, got.insert_rejected);
          err_count++;
        end else begin
          want = expected_sense.pop_front();
          if (got.status_bit !== want.status_bit) begin
            $display("%0t: status_bit expected %0b got %0b",
                     $time, want.status_bit, got.status_bit);
            err_count++;
          end
          if (got.insert_rejected !== want.insert_rejected) begin
            $display("%0t: insert_rejected expected %0b got %0b",
                     $time, want.insert_rejected, got.insert_rejected);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        seen = make_access(in_operation, in_reg_addr, in_cmd_value, in_disk_tracks,
                           in_disk_write_protect, in_disk_high_density, in_disk_gcr);
        want = predict_access(seen);
        expected_sense.push_back(want);
        accepted_cnt <= accepted_cnt + 1;
        case (seen.operation)
          OP_CMD:    cmd_cnt++;
          OP_STATUS: status_cnt++;
          OP_INSERT: insert_cnt++;
          default:   ;
        endcase
        if (want.insert_rejected) reject_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, expected_sense.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    drive             = '0;
    drive.hd_media    = 1'b1;
    drive.mfm_mode    = 1'b1;
    drive.track_limit = TRACK_LIMIT_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: insert a two-track disk, bounce a second insert, walk both clamps
    queue_access(make_access(OP_STATUS, ST_DISK_IN, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_INSERT, 4'd0, 1'b0, 8'd2, 1'b1, 1'b0, 1'b1));
    queue_access(make_access(OP_INSERT, REG_UNKNOWN, 1'b1, 8'd255, 1'b0, 1'b1, 1'b0));
    queue_access(make_access(OP_STATUS, ST_WRITE_PROT, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_MEDIA_KIND, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_DRIVE_MODE, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_DRIVE_MODE, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_SPIN_READY, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_MOTOR, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_MOTOR, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_TRACK_ZERO, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP_DIR, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_STEP, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_SEL_HEAD1, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_SEL_HEAD0, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_EJECT, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, ST_EJECT_LATCH, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, CMD_CLEAR_EJECT, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_CMD, REG_UNKNOWN, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_STATUS, REG_UNKNOWN, 1'b1, 8'd1, 1'b0, 1'b0, 1'b0));
    queue_access(make_access(OP_UNKNOWN, ST_DISK_IN, 1'b1, 8'd255, 1'b1, 1'b1, 1'b1));
    // hold the sender until every result is back
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 62 : 0;
      recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 31 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) queue_access(rand_access());
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d accesses: %0d commands, %0d status reads, %0d inserts (%0d bounced)",
             accepted_cnt, cmd_cnt, status_cnt, insert_cnt, reject_cnt);
    $display("Idle mixes: sender-light, receiver-light and back-to-back; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
